// ===== rtl/core/tea_pkg.sv =====
// Shared types, constants and the round mix function for the TEA core.
// No dependencies; compiled first.
package tea_pkg;

	localparam int WORD_W = 32;
	localparam int CFG_INDEX_W = 8;

	localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_0 = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_1 = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_2 = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_3 = 8'd3;

	// Direction codes
	localparam logic DIR_ENCRYPT = 1'b0;
	localparam logic DIR_DECRYPT = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] lo;
	} tea_blk_t;

	typedef struct packed {
		logic [WORD_W-1:0] k0;
		logic [WORD_W-1:0] k1;
		logic [WORD_W-1:0] k2;
		logic [WORD_W-1:0] k3;
	} tea_key_t;

	function automatic logic [WORD_W-1:0] tea_mix(
		input logic [WORD_W-1:0] w,
		input logic [WORD_W-1:0] sum,
		input logic [WORD_W-1:0] ka,
		input logic [WORD_W-1:0] kb
	);
		logic [WORD_W-1:0] t_shl;
		logic [WORD_W-1:0] t_sum;
		logic [WORD_W-1:0] t_shr;
		t_shl = (w << 4) + ka;
		t_sum = w + sum;
		t_shr = (w >> 5) + kb;
		return t_shl ^ t_sum ^ t_shr;
	endfunction

endpackage

// ===== rtl/core/tea_in_if.sv =====
// Input channel: valid/ready handshake carrying direction and one block.
// Depends on tea_pkg for the word width.
interface tea_in_if;
	import tea_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [WORD_W-1:0] block_high;
	logic [WORD_W-1:0] block_low;

	modport source (output valid, output kind, output block_high, output block_low,
		input ready);
	modport sink (input valid, input kind, input block_high, input block_low,
		output ready);
endinterface

// ===== rtl/core/tea_out_if.sv =====
// Output channel: valid/ready handshake carrying one processed block.
// Depends on tea_pkg for the word width.
interface tea_out_if;
	import tea_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] result_high;
	logic [WORD_W-1:0] result_low;

	modport source (output valid, output result_high, output result_low, input ready);
	modport sink (input valid, input result_high, input result_low, output ready);
endinterface

// ===== rtl/core/tea_front.sv =====
// Front end: accepts words from the input channel into a two-entry queue.
// Depends on tea_pkg and tea_in_if.
module tea_front
	import tea_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	tea_in_if.sink   blk_in,
	input  logic     pop,
	output logic     head_valid,
	output tea_blk_t head
);

	localparam int DEPTH = 2;

	tea_blk_t     mem_q [DEPTH];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         do_pop;
	tea_blk_t     wr_blk;

	assign blk_in.ready = (cnt_q != 2'(DEPTH));
	assign push         = blk_in.valid && blk_in.ready;
	assign head_valid   = (cnt_q != 2'd0);
	assign do_pop       = pop && head_valid;
	assign head         = mem_q[rd_ptr_q];

	// only bit 0 of kind matters; decode it once here
	always_comb begin
		wr_blk.kind = (blk_in.kind == DIR_DECRYPT) ? DIR_DECRYPT : DIR_ENCRYPT;
		wr_blk.hi   = blk_in.block_high;
		wr_blk.lo   = blk_in.block_low;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_blk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/tea_stage.sv =====
// One half-round of TEA as a registered pipeline stage.
// Depends on tea_pkg.
module tea_stage
	import tea_pkg::*;
#(
	parameter int ROUND_COUNT = 16,
	parameter int ROUND       = 0,
	parameter int HALF        = 0
)
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  tea_blk_t in_blk,
	input  tea_key_t key,
	output logic     out_valid,
	output tea_blk_t out_blk
);

	// running sum for this round, worked out at elaboration
	localparam logic [63:0] SUM_ENC_FULL = 64'(TEA_DELTA) * 64'(ROUND + 1);
	localparam logic [63:0] SUM_DEC_FULL = 64'(TEA_DELTA) * 64'(ROUND_COUNT - ROUND);
	localparam logic [WORD_W-1:0] SUM_ENC = SUM_ENC_FULL[WORD_W-1:0];
	localparam logic [WORD_W-1:0] SUM_DEC = SUM_DEC_FULL[WORD_W-1:0];
	localparam logic SECOND = (HALF != 0);

	logic              v_s1;
	tea_blk_t          blk_s1;
	logic              upd_hi;
	logic [WORD_W-1:0] sum;
	logic [WORD_W-1:0] src;
	logic [WORD_W-1:0] ka;
	logic [WORD_W-1:0] kb;
	logic [WORD_W-1:0] dst;
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] dst_nxt;
	tea_blk_t          blk_nxt;

	// encrypt: first half updates hi, second lo; decrypt runs them mirrored
	assign upd_hi = ((in_blk.kind == DIR_DECRYPT) == SECOND);

	always_comb begin
		sum = (in_blk.kind == DIR_DECRYPT) ? SUM_DEC : SUM_ENC;
		if (upd_hi) begin
			src = in_blk.lo;
			dst = in_blk.hi;
			ka  = key.k0;
			kb  = key.k1;
		end else begin
			src = in_blk.hi;
			dst = in_blk.lo;
			ka  = key.k2;
			kb  = key.k3;
		end
		mix     = tea_mix(src, sum, ka, kb);
		dst_nxt = (in_blk.kind == DIR_DECRYPT) ? (dst - mix) : (dst + mix);
		blk_nxt = in_blk;
		if (upd_hi) begin
			blk_nxt.hi = dst_nxt;
		end else begin
			blk_nxt.lo = dst_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			blk_s1 <= blk_nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_blk   = blk_s1;

endmodule

// ===== rtl/core/tea_back.sv =====
// Back end: unrolled chain of half-round stages feeding the output channel.
// Depends on tea_pkg, tea_stage and tea_out_if.
module tea_back
	import tea_pkg::*;
#(
	parameter int ROUND_COUNT = 16
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  tea_blk_t  head,
	input  tea_key_t  key,
	output logic      pop,
	tea_out_if.source blk_out
);

	localparam int NUM_STAGES = 2 * ROUND_COUNT;

	logic     vld [NUM_STAGES+1];
	tea_blk_t blk [NUM_STAGES+1];
	logic     en;

	// whole chain moves unless the last stage holds a word nobody takes
	assign en  = !vld[NUM_STAGES] || blk_out.ready;
	assign pop = en && head_valid;

	assign vld[0] = head_valid;
	assign blk[0] = head;

	for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
		tea_stage #(
			.ROUND_COUNT (ROUND_COUNT),
			.ROUND       (s / 2),
			.HALF        (s % 2)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vld[s]),
			.in_blk    (blk[s]),
			.key       (key),
			.out_valid (vld[s+1]),
			.out_blk   (blk[s+1])
		);
	end

	assign blk_out.valid       = vld[NUM_STAGES];
	assign blk_out.result_high = blk[NUM_STAGES].hi;
	assign blk_out.result_low  = blk[NUM_STAGES].lo;

endmodule

// ===== rtl/core/tea_block_cipher_16_rounds_core.sv =====
// Top level of the TEA block cipher core: key registers, front queue, round pipeline.
// Depends on tea_pkg, tea_in_if, tea_out_if, tea_front and tea_back.
//
//   channel   dir  handshake     payload
//   blk_in    in   valid/ready   kind, block_high, block_low
//   blk_out   out  valid/ready   result_high, result_low
//   cfg       in   cfg_we only   cfg_index, cfg_data (key words 0..3)
//
// Throughput: one word per cycle unless blk_out stalls. Path from acceptance
// to result valid: the front queue shows the word on the cycle after it is
// taken, then one register per half-round (a half-round is one mix plus
// one add/sub).
// Reset clears the queue, all stage valid bits and the key words.
// A stall on blk_out freezes the round chain; the two-entry front queue
// keeps blk_in ready for at most two more words before it backs up.
// Key words are read live by every stage, so write them only while idle.
module tea_block_cipher_16_rounds_core
	import tea_pkg::*;
#(
	parameter int ROUND_COUNT = 16
)
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]      cfg_data,
	tea_in_if.sink                 blk_in,
	tea_out_if.source              blk_out
);

	tea_key_t key_q;
	logic     head_valid;
	tea_blk_t head;
	logic     pop;

	// key register file; indexes past the last key word are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_WORD_0: key_q.k0 <= cfg_data;
				CFG_KEY_WORD_1: key_q.k1 <= cfg_data;
				CFG_KEY_WORD_2: key_q.k2 <= cfg_data;
				CFG_KEY_WORD_3: key_q.k3 <= cfg_data;
				default:        key_q    <= key_q;
			endcase
		end
	end

	tea_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.blk_in     (blk_in),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tea_back #(
		.ROUND_COUNT (ROUND_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.key        (key_q),
		.pop        (pop),
		.blk_out    (blk_out)
	);

endmodule

// ===== tb/tea_cipher_checker.sv =====
// Watches the key writes and both block channels of the TEA core, predicts
// each processed block and compares it with what the core returns.
// Depends on tea_pkg, tea_in_if and tea_out_if.
module tea_cipher_checker
	import tea_pkg::*;
#(
	parameter int ROUND_COUNT = 16
)
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]      cfg_data,
	tea_in_if                      word_in,
	tea_out_if                     word_out,
	output int                     fail_count,
	output int                     pending_words
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] lo;
	} cipher_pair_t;

	tea_key_t     key_copy;
	cipher_pair_t cipher_q[$];

	function automatic logic [WORD_W-1:0] half_round_mix(
		input logic [WORD_W-1:0] w,
		input logic [WORD_W-1:0] s,
		input logic [WORD_W-1:0] ka,
		input logic [WORD_W-1:0] kb
	);
		logic [WORD_W-1:0] left_part;
		logic [WORD_W-1:0] right_part;
		left_part  = (w << 4) + ka;
		right_part = (w >> 5) + kb;
		return left_part ^ (w + s) ^ right_part;
	endfunction

	function automatic cipher_pair_t tea_transform(
		input logic              kind,
		input logic [WORD_W-1:0] hi_in,
		input logic [WORD_W-1:0] lo_in,
		input tea_key_t          k
	);
		logic [WORD_W-1:0] s;
		logic [WORD_W-1:0] h;
		logic [WORD_W-1:0] l;
		cipher_pair_t      res;
		h = hi_in;
		l = lo_in;
		if (kind == DIR_ENCRYPT) begin
			s = '0;
			for (int r = 0; r < ROUND_COUNT; r++) begin
				s = s + TEA_DELTA;
				h = h + half_round_mix(l, s, k.k0, k.k1);
				l = l + half_round_mix(h, s, k.k2, k.k3);
			end
		end else begin
			s = TEA_DELTA * WORD_W'(ROUND_COUNT);
			for (int r = 0; r < ROUND_COUNT; r++) begin
				l = l - half_round_mix(h, s, k.k2, k.k3);
				h = h - half_round_mix(l, s, k.k0, k.k1);
				s = s - TEA_DELTA;
			end
		end
		res.hi = h;
		res.lo = l;
		return res;
	endfunction

	initial begin
		fail_count    = 0;
		pending_words = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		cipher_pair_t want;
		int           errs;
		if (!arst_n) begin
			key_copy = '0;
			cipher_q.delete();
			pending_words <= 0;
		end else begin
			errs = 0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_WORD_0: key_copy.k0 = cfg_data;
					CFG_KEY_WORD_1: key_copy.k1 = cfg_data;
					CFG_KEY_WORD_2: key_copy.k2 = cfg_data;
					CFG_KEY_WORD_3: key_copy.k3 = cfg_data;
					default: ;
				endcase
			end
			if (word_in.valid && word_in.ready)
				cipher_q.push_back(tea_transform(word_in.kind, word_in.block_high,
					word_in.block_low, key_copy));
			if (word_out.valid && word_out.ready) begin
				if (cipher_q.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %08h %08h",
						$time, word_out.result_high, word_out.result_low);
					errs++;
				end else begin
					want = cipher_q.pop_front();
					if (word_out.result_high !== want.hi) begin
						$display("%0t: result_high mismatch, expected %08h, actual %08h",
							$time, want.hi, word_out.result_high);
						errs++;
					end
					if (word_out.result_low !== want.lo) begin
						$display("%0t: result_low mismatch, expected %08h, actual %08h",
							$time, want.lo, word_out.result_low);
						errs++;
					end
				end
			end
			fail_count    <= fail_count + errs;
			pending_words <= cipher_q.size();
		end
	end
endmodule

// ===== tb/tb_tea_block_cipher_16_rounds_core.sv =====
// Testbench top for the TEA core: clock, reset, key writes, block stimulus
// and random back-pressure; checking is left to tea_cipher_checker.
// Depends on tea_pkg, tea_in_if, tea_out_if, tea_cipher_checker and the core.
module tb_tea_block_cipher_16_rounds_core;
	import tea_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROUND_COUNT  = 16;
	// one register per half-round; the front queue adds its own register on top
	localparam int LATENCY      = 2 * ROUND_COUNT;
	localparam int HOLD_CYCLES  = 300;
	localparam int LIMIT_CYCLES = 200000;
	localparam int BATCHES      = 6;
	localparam int BATCH_WORDS  = 165;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [WORD_W-1:0]      cfg_data;

	tea_in_if  blk_in_ch ();
	tea_out_if blk_out_ch ();

	int fail_count;
	int pending_words;
	int cycle_count = 0;

	// idle percentages for each side; changed only between batches
	int send_idle_pct;
	int recv_idle_pct;

	// each flip of hold_token asks the receiver for one long hold-off
	logic hold_token = 1'b0;

	always #6 clk = ~clk;

	tea_block_cipher_16_rounds_core #(
		.ROUND_COUNT(ROUND_COUNT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.blk_in   (blk_in_ch),
		.blk_out  (blk_out_ch)
	);

	tea_cipher_checker #(
		.ROUND_COUNT(ROUND_COUNT)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.word_in      (blk_in_ch),
		.word_out     (blk_out_ch),
		.fail_count   (fail_count),
		.pending_words(pending_words)
	);

	// Watchdog: a hung handshake or a lost result ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver: random ready, or held low through a long hold-off after a token flip.
	// The hold-off is counted here so the sender keeps pushing words meanwhile.
	initial begin
		logic hold_seen;
		int   hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		blk_out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_token) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (!arst_n)
				blk_out_ch.ready <= 1'b0;
			else if (hold_left > 0) begin
				blk_out_ch.ready <= 1'b0;
				hold_left--;
			end else
				blk_out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic tea_key_t make_key(
		input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b,
		input logic [WORD_W-1:0] c,
		input logic [WORD_W-1:0] d
	);
		tea_key_t k;
		k.k0 = a;
		k.k1 = b;
		k.k2 = c;
		k.k3 = d;
		return k;
	endfunction

	// Mostly uniform words, with a share of corner patterns mixed in.
	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] w;
		case ($urandom_range(15))
			0:       w = '0;
			1:       w = '1;
			2:       w = WORD_W'(1) << $urandom_range(WORD_W - 1);
			3:       w = ~(WORD_W'(1) << $urandom_range(WORD_W - 1));
			default: w = $urandom;
		endcase
		return w;
	endfunction

	function automatic logic pick_kind();
		return ($urandom_range(1) == 0) ? DIR_ENCRYPT : DIR_DECRYPT;
	endfunction

	// Offer one word, with a random gap first; returns at the accepting edge.
	task automatic send_word(
		input logic              kind,
		input logic [WORD_W-1:0] hi,
		input logic [WORD_W-1:0] lo
	);
		while ($urandom_range(99) < send_idle_pct) begin
			blk_in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		blk_in_ch.valid      <= 1'b1;
		blk_in_ch.kind       <= kind;
		blk_in_ch.block_high <= hi;
		blk_in_ch.block_low  <= lo;
		@(posedge clk);
		while (!blk_in_ch.ready)
			@(posedge clk);
	endtask

	// Stop offering and wait for every outstanding result. The extra edge lets
	// the checker count a word taken at the edge this is called from.
	task automatic drain();
		blk_in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
	endtask

	// Key words go in back to back, then one write to an unused index that the
	// core must ignore. Only called with the core drained.
	task automatic load_key(input tea_key_t k, input logic [CFG_INDEX_W-1:0] junk_index);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_KEY_WORD_0;
		cfg_data  <= k.k0;
		@(posedge clk);
		cfg_index <= CFG_KEY_WORD_1;
		cfg_data  <= k.k1;
		@(posedge clk);
		cfg_index <= CFG_KEY_WORD_2;
		cfg_data  <= k.k2;
		@(posedge clk);
		cfg_index <= CFG_KEY_WORD_3;
		cfg_data  <= k.k3;
		@(posedge clk);
		cfg_index <= junk_index;
		cfg_data  <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		tea_key_t k;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		blk_in_ch.valid      = 1'b0;
		blk_in_ch.kind       = DIR_ENCRYPT;
		blk_in_ch.block_high = '0;
		blk_in_ch.block_low  = '0;
		send_idle_pct        = 28;
		recv_idle_pct        = 58;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset key (all zero) first, both directions, extreme blocks.
		send_word(DIR_ENCRYPT, '0, '0);
		send_word(DIR_DECRYPT, '0, '0);
		send_word(DIR_ENCRYPT, '1, '1);
		send_word(DIR_DECRYPT, '1, '1);
		drain();

		// all-ones key, and the top index as the ignored write
		load_key(make_key('1, '1, '1, '1), '1);
		send_word(DIR_ENCRYPT, '0, '0);
		send_word(DIR_DECRYPT, '0, '0);
		send_word(DIR_ENCRYPT, '1, '1);
		send_word(DIR_DECRYPT, '1, '1);
		send_word(DIR_ENCRYPT, '0, '1);
		send_word(DIR_DECRYPT, 32'h8000_0000, 32'h0000_0001);
		drain();

		// distinct key words so a swapped key word shows up
		load_key(make_key(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210),
			8'd4);
		send_word(DIR_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
		send_word(DIR_DECRYPT, 32'h0123_4567, 32'h89ab_cdef);
		send_word(DIR_ENCRYPT, '1, '0);
		send_word(DIR_DECRYPT, '0, '1);
		drain();

		// alternating patterns in the key
		load_key(make_key(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa),
			8'h80);
		send_word(DIR_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555);
		send_word(DIR_DECRYPT, 32'h5555_5555, 32'haaaa_aaaa);
		send_word(DIR_ENCRYPT, 32'h0000_0001, 32'h8000_0000);
		send_word(DIR_DECRYPT, 32'h7fff_ffff, 32'hffff_fffe);

		// Random: two batches per idle mode, a fresh key for each batch (a fixed pattern for the last).
		for (int batch = 0; batch < BATCHES; batch++) begin
			drain();
			case (batch / 2)
				0: begin
					send_idle_pct = 28;
					recv_idle_pct = 58;
				end
				1: begin
					send_idle_pct = 58;
					recv_idle_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (batch == BATCHES - 1)
				k = make_key('0, '1, '0, '1);
			else
				k = make_key(pick_word(), pick_word(), pick_word(), pick_word());
			load_key(k, CFG_INDEX_W'($urandom_range(255, 4)));
			for (int n = 0; n < BATCH_WORDS; n++) begin
				// long receiver stall while words keep coming: fills the queue
				if (n == 40 && (batch == 0 || batch == 4))
					hold_token <= ~hold_token;
				// sender pause until the core is empty
				if (n == 100)
					drain();
				send_word(pick_kind(), pick_word(), pick_word());
			end
		end

		drain();
		repeat (LATENCY + 8) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
